[rtl/core/gctl_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gctl_pkg: shared types and constants of the glyph cache tag engine
// Sizes of the entry store and hint table, opcodes and the structs that
// travel between the sequencer and the two memories.
// ---------------------------------------------------------------------------
package gctl_pkg;

   // sizes
   localparam int ENTRIES    = 64;
   localparam int HINT_SLOTS = 256;   // power of two, hint slot is a mask of the key
   localparam int IDX_W      = $clog2(ENTRIES);
   localparam int CNT_W      = $clog2(ENTRIES + 1);
   localparam int HINT_W     = $clog2(HINT_SLOTS);

   // field widths
   localparam int KEY_W  = 21;
   localparam int ADV_W  = 8;
   localparam int AGE_W  = 32;
   localparam int SLOT_W = 6;

   // opcodes
   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_FILL   = 1'b1;

   typedef struct packed {
      logic              en;
      logic [HINT_W-1:0] addr;
   } hint_req_type;

   typedef struct packed {
      logic              en;
      logic [HINT_W-1:0] addr;
      logic [IDX_W-1:0]  idx;
   } hint_wr_type;

   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] idx;
   } hint_rd_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
   } ent_req_type;

   typedef struct packed {
      logic             fill;   // write key, advance, age and set valid
      logic             touch;  // write age only
      logic [IDX_W-1:0] idx;
      logic [KEY_W-1:0] key;
      logic [ADV_W-1:0] adv;
      logic [AGE_W-1:0] age;
   } ent_wr_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
      logic [KEY_W-1:0] key;
      logic [ADV_W-1:0] adv;
      logic [AGE_W-1:0] age;
   } ent_rd_type;

endpackage

[rtl/core/glyph_cache_tag_lru.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// glyph_cache_tag_lru: tag and replacement engine of a glyph cache
// Fully associative 64-entry tag store with age-based replacement and a
// direct-mapped hint table; returns the slot index of the cached glyph.
// ---------------------------------------------------------------------------
//  channel  | handshake           | payload
//  req      | req_valid/req_ready | opcode, codepoint, new_advance
//  rsp      | rsp_valid/rsp_ready | found, slot_index, advance_out, evicted
//
//  A lookup that hits through the hint reads the hint, checks the hinted
//  entry and loads the result. A lookup miss, a scan hit and a fill walk
//  the entry store one entry per cycle through its single read port.
//  Reset clears the entry and hint valid flops at once; no clearing pass.
//  One item is in work at a time; a result that is not taken holds the
//  block in its write-back step until the result register frees.
// ---------------------------------------------------------------------------
module glyph_cache_tag_lru (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_opcode,
   input  logic [gctl_pkg::KEY_W-1:0]  req_codepoint,
   input  logic [gctl_pkg::ADV_W-1:0]  req_new_advance,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_found,
   output logic [gctl_pkg::SLOT_W-1:0] rsp_slot_index,
   output logic [gctl_pkg::ADV_W-1:0]  rsp_advance_out,
   output logic                        rsp_evicted
);
   import gctl_pkg::*;

   hint_req_type hint_req;
   hint_wr_type  hint_wr;
   hint_rd_type  hint_rd;
   ent_req_type  ent_req;
   ent_wr_type   ent_wr;
   ent_rd_type   ent_rd;

   // hint table
   gctl_hint u_hint (
      .clock  (clock),
      .reset  (reset),
      .rd_req (hint_req),
      .wr     (hint_wr),
      .rd     (hint_rd)
   );

   // entry store
   gctl_entries u_entries (
      .clock  (clock),
      .reset  (reset),
      .rd_req (ent_req),
      .wr     (ent_wr),
      .rd     (ent_rd)
   );

   // sequencer and result register
   gctl_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_codepoint   (req_codepoint),
      .req_new_advance (req_new_advance),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_advance_out (rsp_advance_out),
      .rsp_evicted     (rsp_evicted),
      .hint_req        (hint_req),
      .hint_wr         (hint_wr),
      .hint_rd         (hint_rd),
      .ent_req         (ent_req),
      .ent_wr          (ent_wr),
      .ent_rd          (ent_rd)
   );

endmodule

[rtl/core/gctl_hint.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gctl_hint: direct-mapped hint table
// Synchronous memory of entry indexes with one valid flop per slot that
// reset clears; read data is registered.
// ---------------------------------------------------------------------------
module gctl_hint (
   input  logic                  clock,
   input  logic                  reset,
   input  gctl_pkg::hint_req_type rd_req,
   input  gctl_pkg::hint_wr_type  wr,
   output gctl_pkg::hint_rd_type  rd
);
   import gctl_pkg::*;

   logic [IDX_W-1:0]      hint_mem [HINT_SLOTS];
   logic [HINT_SLOTS-1:0] slot_valid_ff;
   logic                  rd_hit_ff;
   logic [IDX_W-1:0]      rd_idx_ff;

   // slot valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else if (wr.en) begin
         slot_valid_ff[wr.addr] <= 1'b1;
      end
   end

   // memory write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         hint_mem[wr.addr] <= wr.idx;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_req.en) begin
         rd_hit_ff <= slot_valid_ff[rd_req.addr];
         rd_idx_ff <= hint_mem[rd_req.addr];
      end
   end

   assign rd.hit = rd_hit_ff;
   assign rd.idx = rd_idx_ff;

endmodule

[rtl/core/gctl_entries.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gctl_entries: cache entry store
// Key, advance and age memories with one read and one write port, plus a
// valid flop per entry that reset clears.
// ---------------------------------------------------------------------------
module gctl_entries (
   input  logic                 clock,
   input  logic                 reset,
   input  gctl_pkg::ent_req_type rd_req,
   input  gctl_pkg::ent_wr_type  wr,
   output gctl_pkg::ent_rd_type  rd
);
   import gctl_pkg::*;

   logic [KEY_W-1:0]   key_mem [ENTRIES];
   logic [ADV_W-1:0]   adv_mem [ENTRIES];
   logic [AGE_W-1:0]   age_mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;

   logic               rd_valid_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic [KEY_W-1:0]   rd_key_ff;
   logic [ADV_W-1:0]   rd_adv_ff;
   logic [AGE_W-1:0]   rd_age_ff;

   // entry valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.fill) begin
         valid_ff[wr.idx] <= 1'b1;
      end
   end

   // memory write port
   always_ff @(posedge clock) begin
      if (wr.fill) begin
         key_mem[wr.idx] <= wr.key;
         adv_mem[wr.idx] <= wr.adv;
      end
      if (wr.fill || wr.touch) begin
         age_mem[wr.idx] <= wr.age;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_req.en) begin
         rd_valid_ff <= valid_ff[rd_req.idx];
         rd_idx_ff   <= rd_req.idx;
         rd_key_ff   <= key_mem[rd_req.idx];
         rd_adv_ff   <= adv_mem[rd_req.idx];
         rd_age_ff   <= age_mem[rd_req.idx];
      end
   end

   assign rd.valid = rd_valid_ff;
   assign rd.idx   = rd_idx_ff;
   assign rd.key   = rd_key_ff;
   assign rd.adv   = rd_adv_ff;
   assign rd.age   = rd_age_ff;

endmodule

[rtl/core/gctl_seq.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gctl_seq: lookup and fill sequencer
// Reads the hint, checks the hinted entry, scans the entry store one entry
// a cycle, then writes back age, entry and hint and loads the result beat.
// ---------------------------------------------------------------------------
module gctl_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_opcode,
   input  logic [gctl_pkg::KEY_W-1:0]  req_codepoint,
   input  logic [gctl_pkg::ADV_W-1:0]  req_new_advance,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_found,
   output logic [gctl_pkg::SLOT_W-1:0] rsp_slot_index,
   output logic [gctl_pkg::ADV_W-1:0]  rsp_advance_out,
   output logic                        rsp_evicted,
   output gctl_pkg::hint_req_type      hint_req,
   output gctl_pkg::hint_wr_type       hint_wr,
   input  gctl_pkg::hint_rd_type       hint_rd,
   output gctl_pkg::ent_req_type       ent_req,
   output gctl_pkg::ent_wr_type        ent_wr,
   input  gctl_pkg::ent_rd_type        ent_rd
);
   import gctl_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_HINT = 3'd1;
   localparam logic [2:0] S_HCHK = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0]        state_ff,     state_in;
   logic              op_ff,        op_in;
   logic [KEY_W-1:0]  key_ff,       key_in;
   logic [ADV_W-1:0]  adv_ff,       adv_in;
   logic [CNT_W-1:0]  iss_ff,       iss_in;
   logic [AGE_W-1:0]  best_ff,      best_in;
   logic [AGE_W-1:0]  age_ff,       age_in;
   logic              res_found_ff, res_found_in;
   logic [IDX_W-1:0]  res_idx_ff,   res_idx_in;
   logic [ADV_W-1:0]  res_adv_ff,   res_adv_in;
   logic              res_evict_ff, res_evict_in;
   logic              res_hint_ff,  res_hint_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [SLOT_W-1:0] rsp_slot_ff,  rsp_slot_in;
   logic [ADV_W-1:0]  rsp_adv_ff,   rsp_adv_in;
   logic              rsp_evict_ff, rsp_evict_in;
   logic              key_hit;
   logic              last_entry;

   assign key_hit    = ent_rd.valid && (ent_rd.key == key_ff);
   assign last_entry = (ent_rd.idx == IDX_W'(ENTRIES - 1));
   assign req_ready  = (state_ff == S_IDLE);

   // next-state and datapath control
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      adv_in       = adv_ff;
      iss_in       = iss_ff;
      best_in      = best_ff;
      age_in       = age_ff;
      res_found_in = res_found_ff;
      res_idx_in   = res_idx_ff;
      res_adv_in   = res_adv_ff;
      res_evict_in = res_evict_ff;
      res_hint_in  = res_hint_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_found_in = rsp_found_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_adv_in   = rsp_adv_ff;
      rsp_evict_in = rsp_evict_ff;
      hint_req     = '0;
      hint_wr      = '0;
      ent_req      = '0;
      ent_wr       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in         = req_opcode;
               key_in        = req_codepoint;
               adv_in        = req_new_advance;
               hint_req.en   = 1'b1;
               hint_req.addr = HINT_W'(req_codepoint % HINT_SLOTS);
               state_in      = S_HINT;
            end
         end
         S_HINT: begin
            ent_req.en = 1'b1;
            if (op_ff == OP_LOOKUP && hint_rd.hit) begin
               ent_req.idx = hint_rd.idx;
               state_in    = S_HCHK;
            end else begin
               ent_req.idx = '0;
               iss_in      = CNT_W'(1);
               best_in     = '1;
               res_idx_in  = '0;
               state_in    = S_SCAN;
            end
         end
         S_HCHK: begin
            if (key_hit) begin
               res_found_in = 1'b1;
               res_idx_in   = ent_rd.idx;
               res_adv_in   = ent_rd.adv;
               res_evict_in = 1'b0;
               res_hint_in  = 1'b0;
               state_in     = S_DONE;
            end else begin
               ent_req.en  = 1'b1;
               ent_req.idx = '0;
               iss_in      = CNT_W'(1);
               best_in     = '1;
               res_idx_in  = '0;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            // check the entry read last cycle
            if (op_ff == OP_LOOKUP) begin
               if (key_hit) begin
                  res_found_in = 1'b1;
                  res_idx_in   = ent_rd.idx;
                  res_adv_in   = ent_rd.adv;
                  res_evict_in = 1'b0;
                  res_hint_in  = 1'b1;
                  state_in     = S_DONE;
               end else if (last_entry) begin
                  res_found_in = 1'b0;
                  res_idx_in   = '0;
                  res_adv_in   = '0;
                  res_evict_in = 1'b0;
                  res_hint_in  = 1'b0;
                  state_in     = S_DONE;
               end
            end else begin
               if (!ent_rd.valid) begin
                  res_found_in = 1'b0;
                  res_idx_in   = ent_rd.idx;
                  res_adv_in   = '0;
                  res_evict_in = 1'b0;
                  res_hint_in  = 1'b1;
                  state_in     = S_DONE;
               end else begin
                  // strictly older keeps the lowest index on ties
                  if (ent_rd.age < best_ff) begin
                     best_in    = ent_rd.age;
                     res_idx_in = ent_rd.idx;
                  end
                  if (last_entry) begin
                     res_found_in = 1'b0;
                     res_adv_in   = '0;
                     res_evict_in = 1'b1;
                     res_hint_in  = 1'b1;
                     state_in     = S_DONE;
                  end
               end
            end
            // issue the next read
            if (state_in == S_SCAN && iss_ff != CNT_W'(ENTRIES)) begin
               ent_req.en  = 1'b1;
               ent_req.idx = iss_ff[IDX_W-1:0];
               iss_in      = iss_ff + CNT_W'(1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_slot_in  = SLOT_W'(res_idx_ff);
               rsp_adv_in   = res_adv_ff;
               rsp_evict_in = res_evict_ff;
               if (op_ff == OP_FILL || res_found_ff) begin
                  age_in = age_ff + AGE_W'(1);
               end
               ent_wr.fill  = (op_ff == OP_FILL);
               ent_wr.touch = (op_ff == OP_LOOKUP) && res_found_ff;
               ent_wr.idx   = res_idx_ff;
               ent_wr.key   = key_ff;
               ent_wr.adv   = adv_ff;
               ent_wr.age   = age_ff + AGE_W'(1);
               hint_wr.en   = res_hint_ff;
               hint_wr.addr = HINT_W'(key_ff % HINT_SLOTS);
               hint_wr.idx  = res_idx_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         age_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         age_ff       <= age_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      adv_ff       <= adv_in;
      iss_ff       <= iss_in;
      best_ff      <= best_in;
      res_found_ff <= res_found_in;
      res_idx_ff   <= res_idx_in;
      res_adv_ff   <= res_adv_in;
      res_evict_ff <= res_evict_in;
      res_hint_ff  <= res_hint_in;
      rsp_found_ff <= rsp_found_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_adv_ff   <= rsp_adv_in;
      rsp_evict_ff <= rsp_evict_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_slot_index  = rsp_slot_ff;
   assign rsp_advance_out = rsp_adv_ff;
   assign rsp_evicted     = rsp_evict_ff;

   // a hit never reports an eviction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_found_ff |-> !rsp_evict_ff)
      else $error("hit beat flagged as eviction");

   // age counter moves only when an item retires
   assert property (@(posedge clock) disable iff (reset)
      !$stable(age_ff) && !$past(reset) |-> $past(state_ff) == S_DONE)
      else $error("age counter changed outside write-back");

   // scan data always belongs to the last issued index
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> ent_rd.idx == IDX_W'(iss_ff - CNT_W'(1)))
      else $error("scan read data out of step with issue counter");

   // memory writes happen only on retirement
   assert property (@(posedge clock) disable iff (reset)
      ent_wr.fill || ent_wr.touch || hint_wr.en |-> rsp_valid_in && state_ff == S_DONE)
      else $error("write-back outside result load");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for glyph_cache_tag_lru
// Drives lookups and fills through the valid/ready request port, predicts
// every result beat with a cycle-free model of the tag store, hint table and
// age-based victim choice, and checks the response port field by field
// across phases of sender idling and receiver stalling.
// ---------------------------------------------------------------------------
module tb;
   import gctl_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int ITEMS_PER_PH = 325;
   localparam int POOL_SIZE    = 96;
   localparam int DRAIN_CYCLES = 80;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] slot;
      logic [ADV_W-1:0]  advance;
      logic              evicted;
   } tag_result_type;

   // predictor of the tag store plus the queue of results still owed
   class glyph_tag_scoreboard;
      bit               ent_valid[ENTRIES];
      bit [KEY_W-1:0]   ent_key[ENTRIES];
      bit [AGE_W-1:0]   ent_age[ENTRIES];
      bit [ADV_W-1:0]   ent_adv[ENTRIES];
      int unsigned      hint_ptr[HINT_SLOTS];   // 0 = no hint, else entry + 1
      bit [AGE_W-1:0]   age_ctr;
      tag_result_type   owed_q[$];
      int               mismatches;

      function new();
         foreach (ent_valid[i]) begin
            ent_valid[i] = 1'b0;
            ent_key[i]   = '0;
            ent_age[i]   = '0;
            ent_adv[i]   = '0;
         end
         foreach (hint_ptr[i]) hint_ptr[i] = 0;
         age_ctr    = '0;
         mismatches = 0;
      endfunction

      // accepted request beat: update the store and queue the expected result
      function void note_request(logic op, logic [KEY_W-1:0] cp, logic [ADV_W-1:0] adv);
         int unsigned slot;
         int unsigned h;
         int          idx;
         bit          hit;
         bit [AGE_W-1:0] oldest;
         tag_result_type res;
         slot = cp % HINT_SLOTS;
         res  = '0;
         hit  = 1'b0;
         idx  = 0;
         if (op == OP_LOOKUP) begin
            // hint first, then the scan in index order
            h = hint_ptr[slot];
            if (h > 0 && h <= ENTRIES && ent_valid[h-1] && ent_key[h-1] == cp) begin
               hit = 1'b1;
               idx = h - 1;
            end else begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (ent_valid[i] && ent_key[i] == cp) begin
                     hit           = 1'b1;
                     idx           = i;
                     hint_ptr[slot] = i + 1;
                     break;
                  end
               end
            end
            if (hit) begin
               age_ctr      = age_ctr + 1;
               ent_age[idx] = age_ctr;
               res.found    = 1'b1;
               res.slot     = idx[SLOT_W-1:0];
               res.advance  = ent_adv[idx];
            end
         end else begin
            // victim: first free entry, else lowest index with smallest age
            oldest = '1;
            for (int i = 0; i < ENTRIES; i++) begin
               if (!ent_valid[i]) begin
                  idx = i;
                  break;
               end
               if (ent_age[i] < oldest) begin
                  oldest = ent_age[i];
                  idx    = i;
               end
            end
            res.evicted    = ent_valid[idx];
            res.slot       = idx[SLOT_W-1:0];
            age_ctr        = age_ctr + 1;
            ent_key[idx]   = cp;
            ent_adv[idx]   = adv;
            ent_age[idx]   = age_ctr;
            ent_valid[idx] = 1'b1;
            hint_ptr[slot] = idx + 1;
         end
         owed_q.push_back(res);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
         end
      endfunction

      // accepted result beat: compare with the oldest owed result
      function void check_response(tag_result_type got);
         tag_result_type want;
         if (owed_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0h", $time, got);
            mismatches++;
            return;
         end
         want = owed_q.pop_front();
         compare_field("found",       32'(want.found),   32'(got.found));
         compare_field("slot_index",  32'(want.slot),    32'(got.slot));
         compare_field("advance_out", 32'(want.advance), 32'(got.advance));
         compare_field("evicted",     32'(want.evicted), 32'(got.evicted));
      endfunction

      function int owed();
         return owed_q.size();
      endfunction
   endclass

   logic              clock           = 1'b0;
   logic              reset           = 1'b1;
   logic              req_valid       = 1'b0;
   logic              req_ready;
   logic              req_opcode      = OP_LOOKUP;
   logic [KEY_W-1:0]  req_codepoint   = '0;
   logic [ADV_W-1:0]  req_new_advance = '0;
   logic              rsp_valid;
   logic              rsp_ready       = 1'b0;
   logic              rsp_found;
   logic [SLOT_W-1:0] rsp_slot_index;
   logic [ADV_W-1:0]  rsp_advance_out;
   logic              rsp_evicted;

   int                idle_pct    = 0;
   int                stall_pct   = 0;
   int unsigned       cycle_count = 0;

   glyph_tag_scoreboard tag_model = new();

   glyph_cache_tag_lru dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_codepoint   (req_codepoint),
      .req_new_advance (req_new_advance),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_advance_out (rsp_advance_out),
      .rsp_evicted     (rsp_evicted)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // result side: check accepted beats, then pick next cycle's ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tag_model.check_response({rsp_found, rsp_slot_index, rsp_advance_out, rsp_evicted});
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // present one request beat, with an optional idle gap first
   task automatic send_item(input logic op, input logic [KEY_W-1:0] cp,
                            input logic [ADV_W-1:0] adv);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_codepoint   <= cp;
      req_new_advance <= adv;
      do @(posedge clock); while (!req_ready);
      tag_model.note_request(op, cp, adv);
   endtask

   initial begin
      logic [KEY_W-1:0] glyph_pool[POOL_SIZE];
      logic [7:0]       low_bytes[24];
      logic             op;
      logic [KEY_W-1:0] cp;

      // keys share a few low bytes so hint slots collide
      foreach (low_bytes[i]) low_bytes[i] = 8'($urandom_range(255));
      foreach (glyph_pool[k])
         glyph_pool[k] = (KEY_W'($urandom_range(16)) << 16)
                       | (KEY_W'($urandom_range(255)) << 8)
                       | KEY_W'(low_bytes[k % 24]);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty miss, extremes, stale hints, duplicate keys
      send_item(OP_LOOKUP, 21'd0,       8'd0);
      send_item(OP_FILL,   21'd0,       8'd0);
      send_item(OP_FILL,   21'd1114111, 8'd255);
      send_item(OP_LOOKUP, 21'd0,       8'd0);
      send_item(OP_LOOKUP, 21'd1114111, 8'd0);
      send_item(OP_FILL,   21'h000100,  8'h5a);
      send_item(OP_LOOKUP, 21'd0,       8'd0);
      send_item(OP_LOOKUP, 21'h000100,  8'd0);
      send_item(OP_FILL,   21'd0,       8'ha5);
      send_item(OP_LOOKUP, 21'd0,       8'd0);
      send_item(OP_LOOKUP, 21'h000100,  8'd0);
      send_item(OP_LOOKUP, 21'd0,       8'd0);
      send_item(OP_LOOKUP, 21'h0fffff,  8'd255);
      send_item(OP_LOOKUP, 21'd1114111, 8'd255);
      send_item(OP_FILL,   21'h0fffff,  8'h80);
      send_item(OP_LOOKUP, 21'h0fffff,  8'd0);

      // random traffic over four idle/stall mixes
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 63; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 63; end
            default: begin idle_pct = 20; stall_pct = 20; end
         endcase
         for (int n = 0; n < ITEMS_PER_PH; n++) begin
            op = ($urandom_range(99) < 35) ? OP_FILL : OP_LOOKUP;
            if ($urandom_range(99) < 88)
               cp = glyph_pool[$urandom_range(POOL_SIZE-1)];
            else
               cp = KEY_W'($urandom_range(1114111));
            send_item(op, cp, 8'($urandom_range(255)));
         end
      end
      req_valid <= 1'b0;

      // drain, then watch for stray beats
      while (tag_model.owed() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tag_model.mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

[glyph_cache_tag_lru.f]
rtl/core/gctl_pkg.sv
rtl/core/gctl_hint.sv
rtl/core/gctl_entries.sv
rtl/core/gctl_seq.sv
rtl/core/glyph_cache_tag_lru.sv
tb/tb.sv
